### hw/rtl/tpc_pkg.sv
// Shared constants, register codes and types of the thruster position controller.
package tpc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_X      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_Y      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRUST_FORCE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY_ACCEL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BODY_MASS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GAIN          = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DAMPING       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_TOLERANCE     = 3'd7;

    localparam logic [31:0] RST_TARGET_X      = 32'd0;
    localparam logic [31:0] RST_TARGET_Y      = 32'd0;
    localparam logic [30:0] RST_THRUST_FORCE  = 31'd1310720;
    localparam logic [31:0] RST_GRAVITY_ACCEL = 32'hFFF60000;
    localparam logic [30:0] RST_BODY_MASS     = 31'd65536;
    localparam logic [30:0] RST_GAIN          = 31'd262144;
    localparam logic [30:0] RST_DAMPING       = 31'd26214;
    localparam logic [30:0] RST_TOLERANCE     = 31'd6554;

    typedef enum logic [2:0] {
        CFG_IDLE,
        CFG_MUL,
        CFG_DIV_A,
        CFG_LOAD_H,
        CFG_DIV_H,
        CFG_FIN
    } cfg_state_t;

    typedef struct packed {
        logic busy;
        logic up_neg;
        logic dn_neg;
    } tpc_cfg_flags_t;

endpackage

### hw/rtl/tpc_cfg_calc.sv
// Derived constants from the force, mass and gravity registers, via a shared serial divider.
module tpc_cfg_calc #(
    parameter int FB = tpc_pkg::FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [30:0]            force_in,
    input  logic [30:0]            mass_in,
    input  logic signed [31:0]     grav_in,
    output logic [FB+31:0]         thr_x,
    output logic [FB+31:0]         thr_up,
    output logic [FB+31:0]         thr_dn,
    output logic signed [63:0]     hover,
    output tpc_pkg::tpc_cfg_flags_t flags
);
    localparam int ALW = 31 + FB;
    localparam int XW  = ALW + 1;
    localparam int DVW = (ALW > 63) ? ALW : 63;
    localparam int CW  = $clog2(DVW);
    localparam int SW  = ALW + 2;

    tpc_pkg::cfg_state_t state_reg, state_next;

    logic [30:0]        f_eff, m_eff;
    logic signed [63:0] gm_reg;
    logic [DVW-1:0]     quo_reg;
    logic [30:0]        rem_reg, div_reg;
    logic [CW-1:0]      cnt_reg;
    logic [ALW-1:0]     acc_reg;
    logic [XW-1:0]      thr_x_reg, thr_up_reg, thr_dn_reg;
    logic signed [63:0] hover_reg;
    logic               up_neg_reg, dn_neg_reg;

    logic [31:0]        trial;
    logic               ge;
    logic [30:0]        rem_next;
    logic [DVW-1:0]     quo_next;
    logic               last_step;
    logic               busy;
    logic [62:0]        gm_mag;
    logic signed [SW-1:0] acc_s, grav_s, xu, xd;

    assign f_eff = (force_in == 31'd0) ? 31'd1 : force_in;
    assign m_eff = (mass_in == 31'd0) ? 31'd1 : mass_in;

    assign trial     = {rem_reg, quo_reg[DVW-1]};
    assign ge        = trial >= {1'b0, div_reg};
    assign rem_next  = ge ? 31'(trial - {1'b0, div_reg}) : trial[30:0];
    assign quo_next  = {quo_reg[DVW-2:0], ge};
    assign last_step = cnt_reg == CW'(DVW - 1);
    assign gm_mag    = gm_reg[63] ? 63'(-gm_reg) : gm_reg[62:0];

    assign acc_s  = $signed({2'b00, acc_reg});
    assign grav_s = SW'(grav_in);
    assign xu     = acc_s + grav_s;
    assign xd     = acc_s - grav_s;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tpc_pkg::CFG_IDLE:   state_next = tpc_pkg::CFG_IDLE;
            tpc_pkg::CFG_MUL:    state_next = tpc_pkg::CFG_DIV_A;
            tpc_pkg::CFG_DIV_A:  if (last_step) state_next = tpc_pkg::CFG_LOAD_H;
            tpc_pkg::CFG_LOAD_H: state_next = tpc_pkg::CFG_DIV_H;
            tpc_pkg::CFG_DIV_H:  if (last_step) state_next = tpc_pkg::CFG_FIN;
            tpc_pkg::CFG_FIN:    state_next = tpc_pkg::CFG_IDLE;
            default:             state_next = tpc_pkg::CFG_IDLE;
        endcase
        if (start) state_next = tpc_pkg::CFG_MUL;
    end

    always_comb begin
        case (state_reg)
            tpc_pkg::CFG_IDLE: busy = 1'b0;
            default:           busy = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpc_pkg::CFG_MUL;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            tpc_pkg::CFG_MUL: begin
                gm_reg  <= -(grav_in * $signed({1'b0, m_eff}));
                quo_reg <= DVW'({f_eff, {FB{1'b0}}});
                div_reg <= m_eff;
                rem_reg <= 31'd0;
                cnt_reg <= '0;
            end
            tpc_pkg::CFG_DIV_A, tpc_pkg::CFG_DIV_H: begin
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + CW'(1);
            end
            tpc_pkg::CFG_LOAD_H: begin
                acc_reg <= quo_reg[ALW-1:0];
                quo_reg <= DVW'(gm_mag);
                div_reg <= f_eff;
                rem_reg <= 31'd0;
                cnt_reg <= '0;
            end
            tpc_pkg::CFG_FIN: begin
                hover_reg  <= gm_reg[63] ? -$signed(64'(quo_reg)) : $signed(64'(quo_reg));
                thr_x_reg  <= XW'(acc_reg) + XW'(1);
                thr_up_reg <= XW'(xu + SW'(1));
                thr_dn_reg <= XW'(xd + SW'(1));
                up_neg_reg <= xu[SW-1];
                dn_neg_reg <= xd[SW-1];
            end
            default: begin
            end
        endcase
    end

    assign thr_x        = thr_x_reg;
    assign thr_up       = thr_up_reg;
    assign thr_dn       = thr_dn_reg;
    assign hover        = hover_reg;
    assign flags.busy   = busy;
    assign flags.up_neg = up_neg_reg;
    assign flags.dn_neg = dn_neg_reg;

endmodule

### hw/rtl/thruster_position_controller.sv
// Top level: register file and six-stage control pipeline ending in the output register.
// Items pass stage registers 1 to 6, which stall independently; m_valid is stage 6.
// Throughput: one item per cycle while s_ready holds high; bubbles are absorbed.
// After reset and after every register write, s_ready stays low while the serial
// divider forms the derived constants.
// Reset is synchronous, active low, and loads the register reset values.
module thruster_position_controller #(
    parameter int FRAC_BITS = tpc_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_pos_x,
    input  logic signed [31:0]          s_pos_y,
    input  logic signed [31:0]          s_vel_x,
    input  logic signed [31:0]          s_vel_y,
    input  logic signed [31:0]          s_heading,
    input  logic signed [31:0]          s_spin_rate,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [16:0]                 m_push_left,
    output logic [16:0]                 m_push_right,
    output logic [16:0]                 m_push_up,
    output logic [16:0]                 m_push_down,
    output logic [16:0]                 m_turn_left,
    output logic [16:0]                 m_turn_right,
    output logic                        m_underpowered
);
    localparam int FB   = FRAC_BITS;
    localparam int ALW  = 31 + FB;
    localparam int XW   = ALW + 1;
    localparam int HW   = (XW + 1) / 2;
    localparam int HIW  = XW - HW;
    localparam int RHW  = XW + 34;
    localparam int SHDN = (FB >= 16) ? (FB - 16) : 0;
    localparam int SHUP = (FB < 16) ? (16 - FB) : 0;
    localparam logic signed [66:0] ONE_W  = 67'sd1 <<< FB;
    localparam logic signed [66:0] NONE_W = -ONE_W;
    localparam logic [FB:0]        ONE_L  = (FB+1)'(1) << FB;

    // register file
    logic signed [31:0] target_x_reg, target_y_reg, gravity_reg;
    logic [30:0] force_reg, mass_reg, gain_reg, damping_reg, tol_reg;
    logic        cfg_wr;
    logic [tpc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg <= tpc_pkg::RST_TARGET_X;
            target_y_reg <= tpc_pkg::RST_TARGET_Y;
            force_reg    <= tpc_pkg::RST_THRUST_FORCE;
            gravity_reg  <= tpc_pkg::RST_GRAVITY_ACCEL;
            mass_reg     <= tpc_pkg::RST_BODY_MASS;
            gain_reg     <= tpc_pkg::RST_GAIN;
            damping_reg  <= tpc_pkg::RST_DAMPING;
            tol_reg      <= tpc_pkg::RST_TOLERANCE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                tpc_pkg::REG_TARGET_X:      target_x_reg <= pwdata;
                tpc_pkg::REG_TARGET_Y:      target_y_reg <= pwdata;
                tpc_pkg::REG_THRUST_FORCE:  force_reg    <= pwdata[30:0];
                tpc_pkg::REG_GRAVITY_ACCEL: gravity_reg  <= pwdata;
                tpc_pkg::REG_BODY_MASS:     mass_reg     <= pwdata[30:0];
                tpc_pkg::REG_GAIN:          gain_reg     <= pwdata[30:0];
                tpc_pkg::REG_DAMPING:       damping_reg  <= pwdata[30:0];
                tpc_pkg::REG_TOLERANCE:     tol_reg      <= pwdata[30:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            tpc_pkg::REG_TARGET_X:      prdata = target_x_reg;
            tpc_pkg::REG_TARGET_Y:      prdata = target_y_reg;
            tpc_pkg::REG_THRUST_FORCE:  prdata = {1'b0, force_reg};
            tpc_pkg::REG_GRAVITY_ACCEL: prdata = gravity_reg;
            tpc_pkg::REG_BODY_MASS:     prdata = {1'b0, mass_reg};
            tpc_pkg::REG_GAIN:          prdata = {1'b0, gain_reg};
            tpc_pkg::REG_DAMPING:       prdata = {1'b0, damping_reg};
            tpc_pkg::REG_TOLERANCE:     prdata = {1'b0, tol_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // derived constants
    logic [XW-1:0]           thr_x, thr_up, thr_dn;
    logic signed [63:0]      hover;
    tpc_pkg::tpc_cfg_flags_t cfg_flags;

    tpc_cfg_calc #(.FB(FB)) u_cfg_calc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_wr),
        .force_in (force_reg),
        .mass_in  (mass_reg),
        .grav_in  (gravity_reg),
        .thr_x    (thr_x),
        .thr_up   (thr_up),
        .thr_dn   (thr_dn),
        .hover    (hover),
        .flags    (cfg_flags)
    );

    // stage flow control
    logic [6:1] vld_reg;
    logic [6:1] vld_in;
    logic [7:1] en;
    logic       s_acc;

    always_comb begin
        en[7] = m_ready;
        for (int i = 6; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[1] && !cfg_flags.busy;
    assign s_acc   = s_valid && s_ready;
    assign vld_in  = {vld_reg[5:1], s_acc};
    assign m_valid = vld_reg[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= 6; i++) begin
                if (en[i]) vld_reg[i] <= vld_in[i];
            end
        end
    end

    logic signed [31:0] gain_s, damp_s;
    assign gain_s = $signed({1'b0, gain_reg});
    assign damp_s = $signed({1'b0, damping_reg});

    // stage 1: offsets
    logic signed [32:0] s1_dx_reg, s1_dy_reg;
    logic signed [31:0] s1_vx_reg, s1_vy_reg, s1_hd_reg, s1_sp_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_dx_reg <= 33'(target_x_reg) - 33'(s_pos_x);
            s1_dy_reg <= 33'(target_y_reg) - 33'(s_pos_y);
            s1_vx_reg <= s_vel_x;
            s1_vy_reg <= s_vel_y;
            s1_hd_reg <= s_heading;
            s1_sp_reg <= s_spin_rate;
        end
    end

    // stage 2: magnitudes, hold window, direction
    logic [32:0] mdx, mdy;
    logic [31:0] mvx, mvy;
    assign mdx = s1_dx_reg[32] ? 33'(-s1_dx_reg) : s1_dx_reg;
    assign mdy = s1_dy_reg[32] ? 33'(-s1_dy_reg) : s1_dy_reg;
    assign mvx = s1_vx_reg[31] ? 32'(-s1_vx_reg) : s1_vx_reg;
    assign mvy = s1_vy_reg[31] ? 32'(-s1_vy_reg) : s1_vy_reg;

    logic [33:0]        s2_denx_reg, s2_deny_reg;
    logic [31:0]        s2_mvx_reg, s2_mvy_reg;
    logic               s2_holdx_reg, s2_holdy_reg;
    logic               s2_dxp_reg, s2_dxn_reg, s2_dyp_reg, s2_dyn_reg;
    logic               s2_vxp_reg, s2_vxn_reg, s2_vyp_reg, s2_vyn_reg;
    logic [XW-1:0]      s2_thry_reg;
    logic               s2_yneg_reg;
    logic signed [32:0] s2_dx_reg, s2_dy_reg;
    logic signed [31:0] s2_vx_reg, s2_vy_reg, s2_hd_reg, s2_sp_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s2_denx_reg  <= {mdx, 1'b0};
            s2_deny_reg  <= {mdy, 1'b0};
            s2_mvx_reg   <= mvx;
            s2_mvy_reg   <= mvy;
            s2_holdx_reg <= (mdx < 33'(tol_reg)) && (mvx < 32'(tol_reg));
            s2_holdy_reg <= (mdy < 33'(tol_reg)) && (mvy < 32'(tol_reg));
            s2_dxp_reg   <= !s1_dx_reg[32] && (s1_dx_reg != 33'sd0);
            s2_dxn_reg   <= s1_dx_reg[32];
            s2_dyp_reg   <= !s1_dy_reg[32] && (s1_dy_reg != 33'sd0);
            s2_dyn_reg   <= s1_dy_reg[32];
            s2_vxp_reg   <= !s1_vx_reg[31] && (s1_vx_reg != 32'sd0);
            s2_vxn_reg   <= s1_vx_reg[31];
            s2_vyp_reg   <= !s1_vy_reg[31] && (s1_vy_reg != 32'sd0);
            s2_vyn_reg   <= s1_vy_reg[31];
            s2_thry_reg  <= s1_dy_reg[32] ? thr_up : thr_dn;
            s2_yneg_reg  <= s1_dy_reg[32] ? cfg_flags.up_neg : cfg_flags.dn_neg;
            s2_dx_reg    <= s1_dx_reg;
            s2_dy_reg    <= s1_dy_reg;
            s2_vx_reg    <= s1_vx_reg;
            s2_vy_reg    <= s1_vy_reg;
            s2_hd_reg    <= s1_hd_reg;
            s2_sp_reg    <= s1_sp_reg;
        end
    end

    // stage 3: products
    logic signed [63:0] s3_khd_reg, s3_csp_reg, s3_cvx_reg, s3_cvy_reg;
    logic signed [64:0] s3_kdx_reg, s3_kdy_reg;
    logic [63:0]        s3_vvx_reg, s3_vvy_reg;
    logic [HW+33:0]     s3_bxl_reg, s3_byl_reg;
    logic [HIW+33:0]    s3_bxh_reg, s3_byh_reg;
    logic               s3_holdx_reg, s3_holdy_reg;
    logic               s3_dxp_reg, s3_dxn_reg, s3_dyp_reg, s3_dyn_reg;
    logic               s3_vxp_reg, s3_vxn_reg, s3_vyp_reg, s3_vyn_reg;
    logic               s3_yneg_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_khd_reg   <= gain_s * s2_hd_reg;
            s3_csp_reg   <= damp_s * s2_sp_reg;
            s3_kdx_reg   <= 65'(gain_s) * 65'(s2_dx_reg);
            s3_cvx_reg   <= damp_s * s2_vx_reg;
            s3_kdy_reg   <= 65'(gain_s) * 65'(s2_dy_reg);
            s3_cvy_reg   <= damp_s * s2_vy_reg;
            s3_vvx_reg   <= 64'(s2_mvx_reg) * 64'(s2_mvx_reg);
            s3_vvy_reg   <= 64'(s2_mvy_reg) * 64'(s2_mvy_reg);
            s3_bxl_reg   <= (HW+34)'(thr_x[HW-1:0]) * (HW+34)'(s2_denx_reg);
            s3_bxh_reg   <= (HIW+34)'(thr_x[XW-1:HW]) * (HIW+34)'(s2_denx_reg);
            s3_byl_reg   <= (HW+34)'(s2_thry_reg[HW-1:0]) * (HW+34)'(s2_deny_reg);
            s3_byh_reg   <= (HIW+34)'(s2_thry_reg[XW-1:HW]) * (HIW+34)'(s2_deny_reg);
            s3_holdx_reg <= s2_holdx_reg;
            s3_holdy_reg <= s2_holdy_reg;
            s3_dxp_reg   <= s2_dxp_reg;
            s3_dxn_reg   <= s2_dxn_reg;
            s3_dyp_reg   <= s2_dyp_reg;
            s3_dyn_reg   <= s2_dyn_reg;
            s3_vxp_reg   <= s2_vxp_reg;
            s3_vxn_reg   <= s2_vxn_reg;
            s3_vyp_reg   <= s2_vyp_reg;
            s3_vyn_reg   <= s2_vyn_reg;
            s3_yneg_reg  <= s2_yneg_reg;
        end
    end

    // stage 4: sums
    logic signed [64:0] s4_rot_reg, s4_hx_reg, s4_hy_reg;
    logic [RHW-1:0]     s4_rhsx_reg, s4_rhsy_reg;
    logic [63:0]        s4_vvx_reg, s4_vvy_reg;
    logic               s4_holdx_reg, s4_holdy_reg;
    logic               s4_dxp_reg, s4_dxn_reg, s4_dyp_reg, s4_dyn_reg;
    logic               s4_vxp_reg, s4_vxn_reg, s4_vyp_reg, s4_vyn_reg;
    logic               s4_yneg_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s4_rot_reg   <= -65'(s3_khd_reg) - 65'(s3_csp_reg);
            s4_hx_reg    <= s3_kdx_reg - 65'(s3_cvx_reg);
            s4_hy_reg    <= s3_kdy_reg - 65'(s3_cvy_reg);
            s4_rhsx_reg  <= (RHW'(s3_bxh_reg) << HW) + RHW'(s3_bxl_reg);
            s4_rhsy_reg  <= (RHW'(s3_byh_reg) << HW) + RHW'(s3_byl_reg);
            s4_vvx_reg   <= s3_vvx_reg;
            s4_vvy_reg   <= s3_vvy_reg;
            s4_holdx_reg <= s3_holdx_reg;
            s4_holdy_reg <= s3_holdy_reg;
            s4_dxp_reg   <= s3_dxp_reg;
            s4_dxn_reg   <= s3_dxn_reg;
            s4_dyp_reg   <= s3_dyp_reg;
            s4_dyn_reg   <= s3_dyn_reg;
            s4_vxp_reg   <= s3_vxp_reg;
            s4_vxn_reg   <= s3_vxn_reg;
            s4_vyp_reg   <= s3_vyp_reg;
            s4_vyn_reg   <= s3_vyn_reg;
            s4_yneg_reg  <= s3_yneg_reg;
        end
    end

    // stage 5: scale, clamp, braking compare
    logic signed [64:0] rot_sh, hx_sh, hy_sh;
    logic signed [FB+1:0] rot_c, hx_c;
    assign rot_sh = s4_rot_reg >>> FB;
    assign hx_sh  = s4_hx_reg >>> FB;
    assign hy_sh  = s4_hy_reg >>> FB;

    always_comb begin
        if (rot_sh > ONE_W)       rot_c = (FB+2)'(ONE_W);
        else if (rot_sh < NONE_W) rot_c = (FB+2)'(NONE_W);
        else                      rot_c = rot_sh[FB+1:0];
        if (hx_sh > ONE_W)        hx_c  = (FB+2)'(ONE_W);
        else if (hx_sh < NONE_W)  hx_c  = (FB+2)'(NONE_W);
        else                      hx_c  = hx_sh[FB+1:0];
    end

    logic signed [FB+1:0] s5_rot_reg, s5_hx_reg;
    logic signed [65:0]   s5_hy_reg;
    logic                 s5_bx_reg, s5_by_reg;
    logic                 s5_holdx_reg, s5_holdy_reg;
    logic                 s5_dxp_reg, s5_dxn_reg, s5_dyp_reg, s5_dyn_reg;
    logic                 s5_vxp_reg, s5_vxn_reg, s5_vyp_reg, s5_vyn_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s5_rot_reg   <= rot_c;
            s5_hx_reg    <= hx_c;
            s5_hy_reg    <= 66'(hover) + 66'(hy_sh);
            s5_bx_reg    <= RHW'(s4_vvx_reg) >= s4_rhsx_reg;
            s5_by_reg    <= s4_yneg_reg || (RHW'(s4_vvy_reg) >= s4_rhsy_reg);
            s5_holdx_reg <= s4_holdx_reg;
            s5_holdy_reg <= s4_holdy_reg;
            s5_dxp_reg   <= s4_dxp_reg;
            s5_dxn_reg   <= s4_dxn_reg;
            s5_dyp_reg   <= s4_dyp_reg;
            s5_dyn_reg   <= s4_dyn_reg;
            s5_vxp_reg   <= s4_vxp_reg;
            s5_vxn_reg   <= s4_vxn_reg;
            s5_vyp_reg   <= s4_vyp_reg;
            s5_vyn_reg   <= s4_vyn_reg;
        end
    end

    // stage 6: thruster selection and output register
    function automatic logic [16:0] to_q16(input logic [FB:0] v);
        return 17'(v >> SHDN) << SHUP;
    endfunction

    logic [FB:0]          lv_l, lv_r, lv_u, lv_d, lv_tl, lv_tr;
    logic signed [FB+1:0] rot_n, hx_n;
    assign rot_n = -s5_rot_reg;
    assign hx_n  = -s5_hx_reg;

    always_comb begin
        lv_l  = '0;
        lv_r  = '0;
        lv_u  = '0;
        lv_d  = '0;
        lv_tl = '0;
        lv_tr = '0;
        if (s5_rot_reg > 0) lv_tl = s5_rot_reg[FB:0];
        else                lv_tr = rot_n[FB:0];
        if (s5_holdx_reg) begin
            if (s5_hx_reg > 0) lv_r = s5_hx_reg[FB:0];
            else               lv_l = hx_n[FB:0];
        end else if (s5_dxp_reg) begin
            if (s5_vxp_reg && s5_bx_reg) lv_l = ONE_L;
            else                         lv_r = ONE_L;
        end else if (s5_dxn_reg) begin
            if (s5_vxn_reg && s5_bx_reg) lv_r = ONE_L;
            else                         lv_l = ONE_L;
        end
        if (s5_holdy_reg) begin
            if (s5_hy_reg < 0)           lv_u = '0;
            else if (s5_hy_reg > ONE_W)  lv_u = ONE_L;
            else                         lv_u = s5_hy_reg[FB:0];
        end else if (s5_dyp_reg) begin
            if (s5_vyp_reg && s5_by_reg) lv_d = ONE_L;
            else                         lv_u = ONE_L;
        end else if (s5_dyn_reg) begin
            if (s5_vyn_reg && s5_by_reg) lv_u = ONE_L;
            else                         lv_d = ONE_L;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            m_push_left    <= to_q16(lv_l);
            m_push_right   <= to_q16(lv_r);
            m_push_up      <= to_q16(lv_u);
            m_push_down    <= to_q16(lv_d);
            m_turn_left    <= to_q16(lv_tl);
            m_turn_right   <= to_q16(lv_tr);
            m_underpowered <= cfg_flags.up_neg;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cfg_flags.busy) else $error("item accepted during constant update");

    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> cfg_flags.busy) else $error("register write did not start update");

    a_turn_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_turn_left == 17'd0 || m_turn_right == 17'd0))
        else $error("both turn levels set");

    a_lat_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_push_left == 17'd0 || m_push_right == 17'd0))
        else $error("both lateral levels set");

    a_vert_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_push_up == 17'd0 || m_push_down == 17'd0))
        else $error("both vertical levels set");

endmodule
